// ----- src/psd_pkg.sv -----
package psd_pkg;

    // Fixed-point format of coordinates and of the distance result.
    localparam int FRAC_BITS = 16;
    localparam int COORD_W   = 32;
    localparam int DIFF_W    = COORD_W + 1;
    localparam int PROD_W    = 2 * DIFF_W;
    localparam int SUM_W     = PROD_W + 1;
    localparam int MAG_W     = PROD_W;
    localparam int HALF_W    = MAG_W / 2;
    localparam int SQ_W      = 2 * COORD_W;
    localparam int DIST_W    = 34;

    // Divider geometry: the quotient never needs more than QUO_W bits.
    localparam int QUO_W     = SUM_W;
    localparam int REM_W     = SUM_W;
    localparam int NUM_W     = REM_W + QUO_W;

    // Square root geometry.
    localparam int RAD_W     = QUO_W + 1;
    localparam int ROOT_W    = RAD_W / 2;
    localparam int SQR_W     = ROOT_W + 3;

    // Pipeline depths.
    localparam int FRONT_LAT = 6;
    localparam int DIV_LAT   = QUO_W + 1;
    localparam int SQRT_LAT  = ROOT_W + 1;
    localparam int TOTAL_LAT = FRONT_LAT + DIV_LAT + 1 + SQRT_LAT + 1;

    // Status codes.
    localparam logic [1:0] ST_ON     = 2'd0;
    localparam logic [1:0] ST_BEFORE = 2'd1;
    localparam logic [1:0] ST_PAST   = 2'd2;
    localparam logic [1:0] ST_NONE   = 2'd3;

    // Sentinel distances.
    localparam logic [DIST_W-1:0] DIST_FAR  = DIST_W'(1000) << FRAC_BITS;
    localparam logic [DIST_W-1:0] DIST_NEAR = DIST_W'(100) << FRAC_BITS;

    // Data that rides beside the divider.
    typedef struct packed {
        logic [1:0]         status;
        logic [SQ_W-1:0]    mz2;
        logic [COORD_W-1:0] ax;
        logic [COORD_W-1:0] ay;
        logic [COORD_W-1:0] bx;
        logic [COORD_W-1:0] by;
        logic               neg_x;
        logic               neg_y;
    } side_t;

    // Front end result handed to the dividers.
    typedef struct packed {
        side_t              side;
        logic [NUM_W-1:0]   num_c;
        logic [NUM_W-1:0]   num_x;
        logic [NUM_W-1:0]   num_y;
        logic [MAG_W-1:0]   len2;
    } front_t;

    // Data that rides beside the square root.
    typedef struct packed {
        logic [1:0]         status;
        logic [COORD_W-1:0] proj_x;
        logic [COORD_W-1:0] proj_y;
    } tail_t;

endpackage

// ----- src/psd_front.sv -----
module psd_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          ends_present,
    input  logic signed [psd_pkg::COORD_W-1:0] begin_x,
    input  logic signed [psd_pkg::COORD_W-1:0] begin_y,
    input  logic signed [psd_pkg::COORD_W-1:0] end_x,
    input  logic signed [psd_pkg::COORD_W-1:0] end_y,
    input  logic signed [psd_pkg::COORD_W-1:0] point_x,
    input  logic signed [psd_pkg::COORD_W-1:0] point_y,
    input  logic signed [psd_pkg::COORD_W-1:0] point_z,
    output logic                          out_valid,
    output psd_pkg::front_t               out_data
);

    // Valid bits, one per stage.
    logic [psd_pkg::FRONT_LAT-1:0] vld_reg;

    // Stage a: differences.
    logic signed [psd_pkg::DIFF_W-1:0]  a_dx_reg, a_dy_reg, a_amx_reg, a_amy_reg;
    logic signed [psd_pkg::COORD_W-1:0] a_mz_reg;
    logic [psd_pkg::COORD_W-1:0]        a_ax_reg, a_ay_reg, a_bx_reg, a_by_reg;
    logic                               a_ends_reg;

    // Stage b: products.
    logic signed [psd_pkg::PROD_W-1:0]  b_sqx_reg, b_sqy_reg, b_px_reg, b_py_reg;
    logic signed [psd_pkg::PROD_W-1:0]  b_cxy_reg, b_cyx_reg;
    logic [psd_pkg::DIFF_W-1:0]         b_adx_reg, b_ady_reg;
    logic                               b_ends_reg;
    psd_pkg::side_t                     b_side_reg;
    logic signed [psd_pkg::SQ_W-1:0]    mz2_next;

    // Stage c: sums.
    logic [psd_pkg::MAG_W-1:0]          c_len2_reg;
    logic signed [psd_pkg::SUM_W-1:0]   c_dot_reg, c_cross_reg;
    logic [psd_pkg::DIFF_W-1:0]         c_adx_reg, c_ady_reg;
    logic                               c_ends_reg;
    psd_pkg::side_t                     c_side_reg;

    // Stage d: classification and magnitudes.
    logic [psd_pkg::MAG_W-1:0]          d_len2_reg, d_cmag_reg, d_dmag_reg;
    logic [psd_pkg::DIFF_W-1:0]         d_adx_reg, d_ady_reg;
    psd_pkg::side_t                     d_side_reg;
    psd_pkg::side_t                     side_next;
    logic [1:0]                         status_next;
    logic signed [psd_pkg::SUM_W-1:0]   cabs_next;

    // Stage e: partial products.
    logic [psd_pkg::PROD_W-1:0]         e_hh_reg, e_hl_reg, e_ll_reg;
    logic [psd_pkg::PROD_W-1:0]         e_xh_reg, e_xl_reg, e_yh_reg, e_yl_reg;
    logic [psd_pkg::MAG_W-1:0]          e_len2_reg;
    psd_pkg::side_t                     e_side_reg;

    // Stage f: assembled numerators.
    psd_pkg::front_t                    f_reg;

    // Two's complement negate of a difference.
    function automatic logic [psd_pkg::DIFF_W-1:0] DIFF_W_NEG(
        input logic [psd_pkg::DIFF_W-1:0] v);
        DIFF_W_NEG = ~v + psd_pkg::DIFF_W'(1);
    endfunction

    // Valid pipeline.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[psd_pkg::FRONT_LAT-2:0], in_valid};
        end
    end

    // Stage a registers the differences from the begin point.
    always_ff @(posedge clk)
    begin
        a_dx_reg   <= $signed({end_x[31], end_x}) - $signed({begin_x[31], begin_x});
        a_dy_reg   <= $signed({end_y[31], end_y}) - $signed({begin_y[31], begin_y});
        a_amx_reg  <= $signed({point_x[31], point_x}) - $signed({begin_x[31], begin_x});
        a_amy_reg  <= $signed({point_y[31], point_y}) - $signed({begin_y[31], begin_y});
        a_mz_reg   <= point_z;
        a_ax_reg   <= begin_x;
        a_ay_reg   <= begin_y;
        a_bx_reg   <= end_x;
        a_by_reg   <= end_y;
        a_ends_reg <= ends_present;
    end

    // Stage b forms the squares, dot and cross products of the differences.
    assign mz2_next = a_mz_reg * a_mz_reg;

    always_ff @(posedge clk)
    begin
        b_sqx_reg         <= a_dx_reg * a_dx_reg;
        b_sqy_reg         <= a_dy_reg * a_dy_reg;
        b_px_reg          <= a_dx_reg * a_amx_reg;
        b_py_reg          <= a_dy_reg * a_amy_reg;
        b_cxy_reg         <= a_dx_reg * a_amy_reg;
        b_cyx_reg         <= a_dy_reg * a_amx_reg;
        b_adx_reg         <= a_dx_reg[psd_pkg::DIFF_W-1] ? DIFF_W_NEG(a_dx_reg) : a_dx_reg;
        b_ady_reg         <= a_dy_reg[psd_pkg::DIFF_W-1] ? DIFF_W_NEG(a_dy_reg) : a_dy_reg;
        b_ends_reg        <= a_ends_reg;
        b_side_reg.status <= psd_pkg::ST_NONE;
        b_side_reg.mz2    <= mz2_next;
        b_side_reg.ax     <= a_ax_reg;
        b_side_reg.ay     <= a_ay_reg;
        b_side_reg.bx     <= a_bx_reg;
        b_side_reg.by     <= a_by_reg;
        b_side_reg.neg_x  <= a_dx_reg[psd_pkg::DIFF_W-1];
        b_side_reg.neg_y  <= a_dy_reg[psd_pkg::DIFF_W-1];
    end

    // Stage c adds up length squared, dot and cross products.
    always_ff @(posedge clk)
    begin
        c_len2_reg  <= b_sqx_reg + b_sqy_reg;
        c_dot_reg   <= {b_px_reg[psd_pkg::PROD_W-1], b_px_reg}
                     + {b_py_reg[psd_pkg::PROD_W-1], b_py_reg};
        c_cross_reg <= {b_cxy_reg[psd_pkg::PROD_W-1], b_cxy_reg}
                     - {b_cyx_reg[psd_pkg::PROD_W-1], b_cyx_reg};
        c_adx_reg   <= b_adx_reg;
        c_ady_reg   <= b_ady_reg;
        c_ends_reg  <= b_ends_reg;
        c_side_reg  <= b_side_reg;
    end

    // Stage d decides where the probe falls relative to the segment.
    always_comb
    begin
        if (!c_ends_reg || c_len2_reg == '0)
        begin
            status_next = psd_pkg::ST_NONE;
        end
        else if (c_dot_reg[psd_pkg::SUM_W-1])
        begin
            status_next = psd_pkg::ST_BEFORE;
        end
        else if (c_dot_reg[psd_pkg::MAG_W-1:0] > c_len2_reg)
        begin
            status_next = psd_pkg::ST_PAST;
        end
        else
        begin
            status_next = psd_pkg::ST_ON;
        end
        cabs_next = c_cross_reg[psd_pkg::SUM_W-1] ? -c_cross_reg : c_cross_reg;
        side_next = c_side_reg;
        side_next.status = status_next;
    end

    always_ff @(posedge clk)
    begin
        d_len2_reg        <= c_len2_reg;
        d_cmag_reg        <= cabs_next[psd_pkg::MAG_W-1:0];
        d_dmag_reg        <= c_dot_reg[psd_pkg::MAG_W-1:0];
        d_adx_reg         <= c_adx_reg;
        d_ady_reg         <= c_ady_reg;
        d_side_reg        <= side_next;
    end

    // Stage e splits the wide products into half-width multiplies.
    always_ff @(posedge clk)
    begin
        e_hh_reg   <= d_cmag_reg[psd_pkg::MAG_W-1:psd_pkg::HALF_W]
                    * d_cmag_reg[psd_pkg::MAG_W-1:psd_pkg::HALF_W];
        e_hl_reg   <= d_cmag_reg[psd_pkg::MAG_W-1:psd_pkg::HALF_W]
                    * d_cmag_reg[psd_pkg::HALF_W-1:0];
        e_ll_reg   <= d_cmag_reg[psd_pkg::HALF_W-1:0] * d_cmag_reg[psd_pkg::HALF_W-1:0];
        e_xh_reg   <= d_adx_reg * d_dmag_reg[psd_pkg::MAG_W-1:psd_pkg::HALF_W];
        e_xl_reg   <= d_adx_reg * d_dmag_reg[psd_pkg::HALF_W-1:0];
        e_yh_reg   <= d_ady_reg * d_dmag_reg[psd_pkg::MAG_W-1:psd_pkg::HALF_W];
        e_yl_reg   <= d_ady_reg * d_dmag_reg[psd_pkg::HALF_W-1:0];
        e_len2_reg <= d_len2_reg;
        e_side_reg <= d_side_reg;
    end

    // Stage f reassembles the dividends.
    always_ff @(posedge clk)
    begin
        f_reg.num_c <= psd_pkg::NUM_W'({e_hh_reg, {psd_pkg::MAG_W{1'b0}}})
                     + psd_pkg::NUM_W'({e_hl_reg, {(psd_pkg::HALF_W + 1){1'b0}}})
                     + psd_pkg::NUM_W'(e_ll_reg);
        f_reg.num_x <= psd_pkg::NUM_W'({e_xh_reg, {psd_pkg::HALF_W{1'b0}}})
                     + psd_pkg::NUM_W'(e_xl_reg);
        f_reg.num_y <= psd_pkg::NUM_W'({e_yh_reg, {psd_pkg::HALF_W{1'b0}}})
                     + psd_pkg::NUM_W'(e_yl_reg);
        f_reg.len2  <= e_len2_reg;
        f_reg.side  <= e_side_reg;
    end

    assign out_valid = vld_reg[psd_pkg::FRONT_LAT-1];
    assign out_data  = f_reg;

endmodule

// ----- src/psd_divider.sv -----
module psd_divider (
    input  logic                        clk,
    input  logic [psd_pkg::NUM_W-1:0]   num,
    input  logic [psd_pkg::MAG_W-1:0]   den,
    output logic [psd_pkg::QUO_W-1:0]   quo
);

    // One restoring step per stage, one quotient bit each.
    logic [psd_pkg::REM_W-1:0] rem_reg [psd_pkg::QUO_W+1];
    logic [psd_pkg::QUO_W-1:0] low_reg [psd_pkg::QUO_W+1];
    logic [psd_pkg::QUO_W-1:0] quo_reg [psd_pkg::QUO_W+1];
    logic [psd_pkg::MAG_W-1:0] den_reg [psd_pkg::QUO_W+1];

    // Input stage: the upper dividend bits are already below the divisor.
    always_ff @(posedge clk)
    begin
        rem_reg[0] <= num[psd_pkg::NUM_W-1:psd_pkg::QUO_W];
        low_reg[0] <= num[psd_pkg::QUO_W-1:0];
        quo_reg[0] <= '0;
        den_reg[0] <= den;
    end

    for (genvar k = 0; k < psd_pkg::QUO_W; k++)
    begin : g_step
        logic [psd_pkg::REM_W-1:0] shift_val;
        logic [psd_pkg::REM_W:0]   diff_val;
        logic [psd_pkg::REM_W-1:0] rem_next;

        // Bring down the next dividend bit and try the subtraction.
        assign shift_val = {rem_reg[k][psd_pkg::REM_W-2:0], low_reg[k][psd_pkg::QUO_W-1]};
        assign diff_val  = {1'b0, shift_val} - {2'b00, den_reg[k]};
        assign rem_next  = diff_val[psd_pkg::REM_W] ? shift_val
                                                    : diff_val[psd_pkg::REM_W-1:0];

        always_ff @(posedge clk)
        begin
            rem_reg[k+1] <= rem_next;
            low_reg[k+1] <= {low_reg[k][psd_pkg::QUO_W-2:0], 1'b0};
            quo_reg[k+1] <= {quo_reg[k][psd_pkg::QUO_W-2:0], ~diff_val[psd_pkg::REM_W]};
            den_reg[k+1] <= den_reg[k];
        end
    end

    assign quo = quo_reg[psd_pkg::QUO_W];

endmodule

// ----- src/psd_sqrt.sv -----
module psd_sqrt (
    input  logic                        clk,
    input  logic [psd_pkg::RAD_W-1:0]   rad,
    output logic [psd_pkg::ROOT_W-1:0]  root
);

    // One root bit per stage, digit by digit.
    logic [psd_pkg::SQR_W-1:0]  rem_reg  [psd_pkg::ROOT_W+1];
    logic [psd_pkg::RAD_W-1:0]  rad_reg  [psd_pkg::ROOT_W+1];
    logic [psd_pkg::ROOT_W-1:0] root_reg [psd_pkg::ROOT_W+1];

    always_ff @(posedge clk)
    begin
        rem_reg[0]  <= '0;
        rad_reg[0]  <= rad;
        root_reg[0] <= '0;
    end

    for (genvar k = 0; k < psd_pkg::ROOT_W; k++)
    begin : g_step
        logic [psd_pkg::SQR_W-1:0] shift_val;
        logic [psd_pkg::SQR_W:0]   diff_val;
        logic [psd_pkg::SQR_W-1:0] rem_next;

        // Bring down two radicand bits and test root*4+1.
        assign shift_val = {rem_reg[k][psd_pkg::SQR_W-3:0],
                            rad_reg[k][psd_pkg::RAD_W-1:psd_pkg::RAD_W-2]};
        assign diff_val  = {1'b0, shift_val} - {2'b00, root_reg[k], 2'b01};
        assign rem_next  = diff_val[psd_pkg::SQR_W] ? shift_val
                                                    : diff_val[psd_pkg::SQR_W-1:0];

        always_ff @(posedge clk)
        begin
            rem_reg[k+1]  <= rem_next;
            rad_reg[k+1]  <= {rad_reg[k][psd_pkg::RAD_W-3:0], 2'b00};
            root_reg[k+1] <= {root_reg[k][psd_pkg::ROOT_W-2:0], ~diff_val[psd_pkg::SQR_W]};
        end
    end

    assign root = root_reg[psd_pkg::ROOT_W];

endmodule

// ----- src/point_segment_distance_projection_top.sv -----
// Channel   Signals                                        Transfer
// command   start, busy, ends_present, begin_*, end_*,     start high while busy low
//           point_x, point_y, point_z
// result    done, dist_res, proj_x, proj_y, seg_status     done high for one cycle
//
// A command is taken every cycle; busy stays low.
// Each result passes through the front end (6 stages), the 68-stage divider,
// the 35-stage square root and two joining registers.
// Results leave in command order, one per command, and cannot be held off.
// Reset clears the valid bits only; the datapath registers are not reset.
module point_segment_distance_projection_top (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic                               ends_present,
    input  logic signed [psd_pkg::COORD_W-1:0] begin_x,
    input  logic signed [psd_pkg::COORD_W-1:0] begin_y,
    input  logic signed [psd_pkg::COORD_W-1:0] end_x,
    input  logic signed [psd_pkg::COORD_W-1:0] end_y,
    input  logic signed [psd_pkg::COORD_W-1:0] point_x,
    input  logic signed [psd_pkg::COORD_W-1:0] point_y,
    input  logic signed [psd_pkg::COORD_W-1:0] point_z,
    output logic                               done,
    output logic [psd_pkg::DIST_W-1:0]         dist_res,
    output logic signed [psd_pkg::COORD_W-1:0] proj_x,
    output logic signed [psd_pkg::COORD_W-1:0] proj_y,
    output logic [1:0]                         seg_status
);

    logic                          front_valid;
    psd_pkg::front_t               front_data;
    logic [psd_pkg::QUO_W-1:0]     quo_c, quo_x, quo_y;
    logic [psd_pkg::ROOT_W-1:0]    root;

    logic [psd_pkg::DIV_LAT-1:0]   dvld_reg;
    psd_pkg::side_t                side_reg [psd_pkg::DIV_LAT];
    logic                          g_vld_reg;
    logic [psd_pkg::RAD_W-1:0]     g_rad_reg;
    psd_pkg::tail_t                g_tail_reg;
    psd_pkg::tail_t                g_tail_next;
    logic [psd_pkg::SQRT_LAT-1:0]  svld_reg;
    psd_pkg::tail_t                tail_reg [psd_pkg::SQRT_LAT];
    psd_pkg::side_t                side_out;
    psd_pkg::tail_t                tail_out;

    logic                          done_reg;
    logic [psd_pkg::DIST_W-1:0]    dist_reg;
    logic [psd_pkg::COORD_W-1:0]   proj_x_reg, proj_y_reg;
    logic [1:0]                    status_reg;
    logic [psd_pkg::DIST_W-1:0]    dist_next;
    logic [psd_pkg::COORD_W-1:0]   off_x, off_y;

    assign busy = 1'b0;

    // Differences, products, classification and dividends.
    psd_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (start),
        .ends_present (ends_present),
        .begin_x      (begin_x),
        .begin_y      (begin_y),
        .end_x        (end_x),
        .end_y        (end_y),
        .point_x      (point_x),
        .point_y      (point_y),
        .point_z      (point_z),
        .out_valid    (front_valid),
        .out_data     (front_data)
    );

    // Three dividers by the squared length run side by side.
    psd_divider u_div_c (
        .clk (clk),
        .num (front_data.num_c),
        .den (front_data.len2),
        .quo (quo_c)
    );

    psd_divider u_div_x (
        .clk (clk),
        .num (front_data.num_x),
        .den (front_data.len2),
        .quo (quo_x)
    );

    psd_divider u_div_y (
        .clk (clk),
        .num (front_data.num_y),
        .den (front_data.len2),
        .quo (quo_y)
    );

    // Valid bits beside the dividers and the square root.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dvld_reg  <= '0;
            g_vld_reg <= 1'b0;
            svld_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            dvld_reg  <= {dvld_reg[psd_pkg::DIV_LAT-2:0], front_valid};
            g_vld_reg <= dvld_reg[psd_pkg::DIV_LAT-1];
            svld_reg  <= {svld_reg[psd_pkg::SQRT_LAT-2:0], g_vld_reg};
            done_reg  <= svld_reg[psd_pkg::SQRT_LAT-1];
        end
    end

    // Side data delay line across the dividers.
    always_ff @(posedge clk)
    begin
        side_reg[0] <= front_data.side;
        for (int i = 1; i < psd_pkg::DIV_LAT; i++)
        begin
            side_reg[i] <= side_reg[i-1];
        end
    end

    assign side_out = side_reg[psd_pkg::DIV_LAT-1];
    assign off_x    = quo_x[psd_pkg::COORD_W-1:0];
    assign off_y    = quo_y[psd_pkg::COORD_W-1:0];

    // Projection point per status; the offset moves toward the end point.
    always_comb
    begin
        g_tail_next.status = side_out.status;
        case (side_out.status)
            psd_pkg::ST_ON:
            begin
                g_tail_next.proj_x = side_out.neg_x ? side_out.ax - off_x : side_out.ax + off_x;
                g_tail_next.proj_y = side_out.neg_y ? side_out.ay - off_y : side_out.ay + off_y;
            end
            psd_pkg::ST_BEFORE:
            begin
                g_tail_next.proj_x = side_out.ax;
                g_tail_next.proj_y = side_out.ay;
            end
            psd_pkg::ST_PAST:
            begin
                g_tail_next.proj_x = side_out.bx;
                g_tail_next.proj_y = side_out.by;
            end
            default:
            begin
                g_tail_next.proj_x = '0;
                g_tail_next.proj_y = '0;
            end
        endcase
    end

    // Squared distance is the cross quotient plus the height squared.
    always_ff @(posedge clk)
    begin
        g_rad_reg  <= {1'b0, quo_c} + psd_pkg::RAD_W'(side_out.mz2);
        g_tail_reg <= g_tail_next;
    end

    psd_sqrt u_sqrt (
        .clk  (clk),
        .rad  (g_rad_reg),
        .root (root)
    );

    // Result data delay line across the square root.
    always_ff @(posedge clk)
    begin
        tail_reg[0] <= g_tail_reg;
        for (int i = 1; i < psd_pkg::SQRT_LAT; i++)
        begin
            tail_reg[i] <= tail_reg[i-1];
        end
    end

    assign tail_out = tail_reg[psd_pkg::SQRT_LAT-1];

    // Sentinels replace the distance off the segment.
    always_comb
    begin
        case (tail_out.status)
            psd_pkg::ST_ON:                     dist_next = root;
            psd_pkg::ST_BEFORE, psd_pkg::ST_PAST: dist_next = psd_pkg::DIST_NEAR;
            default:                            dist_next = psd_pkg::DIST_FAR;
        endcase
    end

    always_ff @(posedge clk)
    begin
        dist_reg   <= dist_next;
        proj_x_reg <= tail_out.proj_x;
        proj_y_reg <= tail_out.proj_y;
        status_reg <= tail_out.status;
    end

    assign done       = done_reg;
    assign dist_res   = dist_reg;
    assign proj_x     = proj_x_reg;
    assign proj_y     = proj_y_reg;
    assign seg_status = status_reg;

    // Every command yields its result after the fixed latency.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##(psd_pkg::TOTAL_LAT) done)
        else $error("result missing after command");

    // No result without a command.
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, psd_pkg::TOTAL_LAT))
        else $error("result without command");

    // Off the segment the distance is a sentinel.
    a_sentinel: assert property (@(posedge clk) disable iff (!rst_n)
        done && seg_status != psd_pkg::ST_ON |->
            dist_res == psd_pkg::DIST_FAR || dist_res == psd_pkg::DIST_NEAR)
        else $error("sentinel distance wrong");

    // Missing ends or a zero-length segment project to the origin.
    a_origin: assert property (@(posedge clk) disable iff (!rst_n)
        done && seg_status == psd_pkg::ST_NONE |-> proj_x == '0 && proj_y == '0)
        else $error("projection not at origin");

endmodule
